>>> design/bli_pkg.sv
`default_nettype none
// bli_pkg: shared constants, operation codes and word types for the bounded list
// no dependencies; imported by bli_cell, bounded_list_insert_delete and the bench
package bli_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 4;
    localparam int POS_W       = 5;
    localparam int CNT_FIELD_W = 5;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);

    localparam logic [KIND_W-1:0] KIND_INS_FRONT  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_INS_REAR   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_INS_POS    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_INS_SORTED = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_DEL_REAR   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_DEL_FIRST  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_DEL_ALL    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_READ       = 4'd8;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } cmd_word_t;

    typedef struct packed {
        logic                     ok;
        logic [CNT_FIELD_W-1:0]   element_count;
        logic signed [DATA_W-1:0] read_value;
    } rsp_word_t;

    typedef struct packed {
        logic eval;
        logic apply;
        logic ins;
        logic eq_en;
        logic le_en;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> design/bli_cell.sv
`default_nettype none
// bli_cell: one list slot with its compare flag and neighbor shift
// depends on bli_pkg
module bli_cell (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire bli_pkg::cell_ctl_t           ctl,
    input  wire logic signed [bli_pkg::DATA_W-1:0] value,
    input  wire logic signed [bli_pkg::DATA_W-1:0] left_data,
    input  wire logic signed [bli_pkg::DATA_W-1:0] right_data,
    input  wire                               idx_hit,
    input  wire                               in_range,
    input  wire                               before_in,
    output logic signed [bli_pkg::DATA_W-1:0] data,
    output logic                              before_out
);
    import bli_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic                     cmp_hit;

    assign cmp_hit = in_range & ((ctl.eq_en & (data_reg == value))
                               | (ctl.le_en & !(value > data_reg)));

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.eval)
        begin
            hit_next = idx_hit | cmp_hit;
        end
    end

    always_comb
    begin
        data_next = data_reg;
        if (ctl.apply)
        begin
            if (ctl.ins)
            begin
                if (before_in)
                begin
                    data_next = left_data;
                end
                else if (hit_reg)
                begin
                    data_next = value;
                end
            end
            else if (before_in | hit_reg)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data       = data_reg;
    assign before_out = before_in | hit_reg;

endmodule
`default_nettype wire

>>> design/bounded_list_insert_delete.sv
`default_nettype none
// bounded_list_insert_delete: top level, operation sequencer, count and result word
// depends on bli_pkg and bli_cell
//
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// One command word is taken at a time and gives one response word. Reads, rear
// deletes, unknown kinds and commands that fail on a full or empty list or a bad
// position are latched and then go straight to loading the response. Other
// inserts and deletes are latched, then pass through a compare step in which
// every cell compares itself against the command, a shift step in which the
// cells shift toward or away from the first hit (a ripple along the row), and
// the response load. Delete-all repeats the compare and shift pair once per
// removed entry plus once more. The response is loaded only once the previous
// one has been taken. A new command is taken while the previous response waits.
module bounded_list_insert_delete (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    input  wire bli_pkg::cmd_word_t cmd,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output bli_pkg::rsp_word_t  rsp
);
    import bli_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    cmd_word_t        op_reg;
    cmd_word_t        op_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ok_reg;
    logic             ok_next;
    rsp_word_t        rsp_reg;
    rsp_word_t        rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY:0]        before_chain;
    logic [CAPACITY-1:0]      idx_hit;
    logic [CAPACITY-1:0]      in_range;
    logic                     any_hit;
    logic                     full;
    logic                     empty;

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign any_hit = before_chain[CAPACITY];
    assign before_chain[0] = 1'b0;

    always_comb
    begin
        ctl.eval  = (state_reg == ST_EVAL);
        ctl.apply = (state_reg == ST_APPLY);
        ctl.ins   = (op_reg.kind == KIND_INS_FRONT) || (op_reg.kind == KIND_INS_REAR)
                 || (op_reg.kind == KIND_INS_POS) || (op_reg.kind == KIND_INS_SORTED);
        ctl.eq_en = (op_reg.kind == KIND_DEL_FIRST) || (op_reg.kind == KIND_DEL_ALL);
        ctl.le_en = (op_reg.kind == KIND_INS_SORTED);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;

            always_comb
            begin
                in_range[gi] = (CNT_W'(gi) < count_reg);
                case (op_reg.kind)
                    KIND_INS_FRONT:  idx_hit[gi] = (gi == 0);
                    KIND_DEL_FRONT:  idx_hit[gi] = (gi == 0);
                    KIND_INS_REAR:   idx_hit[gi] = (CNT_W'(gi) == count_reg);
                    KIND_INS_SORTED: idx_hit[gi] = (CNT_W'(gi) == count_reg);
                    KIND_INS_POS:    idx_hit[gi] = (32'(gi) == 32'(op_reg.position));
                    default:         idx_hit[gi] = 1'b0;
                endcase
            end

            if (gi == 0)
            begin : g_first
                assign left_d = op_reg.value;
            end
            else
            begin : g_mid
                assign left_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_inner
                assign right_d = cell_data[gi+1];
            end

            bli_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .value      (op_reg.value),
                .left_data  (left_d),
                .right_data (right_d),
                .idx_hit    (idx_hit[gi]),
                .in_range   (in_range[gi]),
                .before_in  (before_chain[gi]),
                .data       (cell_data[gi]),
                .before_out (before_chain[gi+1])
            );
        end
    endgenerate

    assign cmd_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd;
                    ok_next    = 1'b0;
                    state_next = ST_FIN;
                    case (cmd.kind)
                        KIND_INS_FRONT, KIND_INS_REAR, KIND_INS_SORTED:
                        begin
                            if (!full)
                            begin
                                state_next = ST_EVAL;
                            end
                        end
                        KIND_INS_POS:
                        begin
                            if (!full && (32'(cmd.position) <= 32'(count_reg)))
                            begin
                                state_next = ST_EVAL;
                            end
                        end
                        KIND_DEL_FRONT, KIND_DEL_FIRST, KIND_DEL_ALL:
                        begin
                            if (!empty)
                            begin
                                state_next = ST_EVAL;
                            end
                        end
                        KIND_DEL_REAR:
                        begin
                            if (!empty)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                ok_next    = 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            ok_next = (32'(cmd.position) < 32'(count_reg));
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_FIN;
                if (any_hit)
                begin
                    ok_next = 1'b1;
                    if (ctl.ins)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    if (op_reg.kind == KIND_DEL_ALL)
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.ok            = ok_reg;
                    rsp_next.element_count = CNT_FIELD_W'(count_reg);
                    rsp_next.read_value    = '0;
                    if ((op_reg.kind == KIND_READ) && ok_reg)
                    begin
                        rsp_next.read_value = cell_data[op_reg.position[IDX_W-1:0]];
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ok_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ok_reg        <= ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire

>>> sim/bounded_list_insert_delete_test.sv
`timescale 1ns / 1ps
// bounded_list_insert_delete_test: self-checking bench for the bounded ordered list
// depends on bli_pkg and bounded_list_insert_delete; predicts every response word
module bounded_list_insert_delete_test;

    import bli_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 95;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    cmd_word_t cmd;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp;

    cmd_word_t cmd_backlog [$];
    rsp_word_t pending_rsp [$];

    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int list_len;

    int  send_gap_pct;
    int  rsp_stall_pct;
    int  mismatches;
    int  quiet_cycles;
    logic cmd_fire;

    bounded_list_insert_delete DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void put_entry(int at, logic signed [DATA_W-1:0] v);
        int k;
        for (k = list_len; k > at; k--)
            list_mem[k] = list_mem[k - 1];
        list_mem[at] = v;
        list_len++;
    endfunction

    function automatic void drop_entry(int at);
        int k;
        for (k = at; k + 1 < list_len; k++)
            list_mem[k] = list_mem[k + 1];
        list_len--;
    endfunction

    function automatic rsp_word_t list_apply(cmd_word_t c);
        rsp_word_t r;
        int   i;
        int   w;
        logic full;
        logic empty;
        logic found;
        r = '0;
        full = (list_len >= CAPACITY);
        empty = (list_len == 0);
        found = 1'b0;
        case (c.kind)
            KIND_INS_FRONT:
                if (!full)
                begin
                    put_entry(0, c.value);
                    r.ok = 1'b1;
                end
            KIND_INS_REAR:
                if (!full)
                begin
                    put_entry(list_len, c.value);
                    r.ok = 1'b1;
                end
            KIND_INS_POS:
                if (!full && int'(c.position) <= list_len)
                begin
                    put_entry(int'(c.position), c.value);
                    r.ok = 1'b1;
                end
            KIND_INS_SORTED:
                if (!full)
                begin
                    i = 0;
                    while (i < list_len && c.value > list_mem[i])
                        i++;
                    put_entry(i, c.value);
                    r.ok = 1'b1;
                end
            KIND_DEL_FRONT:
                if (!empty)
                begin
                    drop_entry(0);
                    r.ok = 1'b1;
                end
            KIND_DEL_REAR:
                if (!empty)
                begin
                    list_len--;
                    r.ok = 1'b1;
                end
            KIND_DEL_FIRST:
                for (i = 0; i < list_len && !found; i++)
                begin
                    if (list_mem[i] == c.value)
                    begin
                        drop_entry(i);
                        found = 1'b1;
                        r.ok = 1'b1;
                    end
                end
            KIND_DEL_ALL:
            begin
                w = 0;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_mem[i] == c.value)
                        r.ok = 1'b1;
                    else
                    begin
                        list_mem[w] = list_mem[i];
                        w++;
                    end
                end
                list_len = w;
            end
            KIND_READ:
                if (int'(c.position) < list_len)
                begin
                    r.read_value = list_mem[c.position];
                    r.ok = 1'b1;
                end
            default:
                ;
        endcase
        r.element_count = list_len[CNT_FIELD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            5: return 32'sd5;
            6: return -32'sd5;
            7: return 32'sh55555555;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_word_t random_cmd(logic grow);
        cmd_word_t c;
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 4)
            c.kind = KIND_READ + KIND_W'($urandom_range(1, 7));
        else if (r < 20)
            c.kind = KIND_READ;
        else if (r < (grow ? 84 : 36))
            c.kind = KIND_INS_FRONT + KIND_W'($urandom_range(0, 3));
        else
            c.kind = KIND_DEL_FRONT + KIND_W'($urandom_range(0, 3));
        c.value = pick_value();
        p = $urandom_range(0, 99);
        if (p < 50)
            c.position = POS_W'($urandom_range(0, 8));
        else if (p < 90)
            c.position = POS_W'($urandom_range(0, 16));
        else
            c.position = POS_W'($urandom_range(17, 31));
        return c;
    endfunction

    task automatic queue_cmd(logic [KIND_W-1:0] k, logic signed [DATA_W-1:0] v,
                             logic [POS_W-1:0] p);
        cmd_word_t c;
        c.kind = k;
        c.value = v;
        c.position = p;
        cmd_backlog.push_back(c);
    endtask

    task automatic run_phase(int gap_pct, int stall_pct);
        int n;
        send_gap_pct = gap_pct;
        rsp_stall_pct = stall_pct;
        for (n = 0; n < ITEMS_PER_PHASE; n++)
            cmd_backlog.push_back(random_cmd(((n / 40) % 2) == 0));
        while (cmd_backlog.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_valid || cmd_fire)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    cmd <= cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n)
        begin
            cmd_fire <= cmd_valid && cmd_ready;
            if (cmd_valid && cmd_ready)
                pending_rsp.push_back(list_apply(cmd));
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response word %p", rsp);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.ok !== want.ok || rsp.element_count !== want.element_count
                        || rsp.read_value !== want.read_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response mismatch: expected %p, got %p", want, rsp);
                    end
                end
            end
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        rsp_ready = 1'b0;
        cmd_fire = 1'b0;
        send_gap_pct = 0;
        rsp_stall_pct = 0;
        mismatches = 0;
        quiet_cycles = 0;
        list_len = 0;
        foreach (list_mem[i])
            list_mem[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list, unknown kind, bad positions
        queue_cmd(KIND_READ, 32'sd0, 5'd0);
        queue_cmd(KIND_DEL_FRONT, 32'sd0, 5'd0);
        queue_cmd(KIND_DEL_REAR, 32'sd0, 5'd0);
        queue_cmd(KIND_DEL_FIRST, 32'sd0, 5'd0);
        queue_cmd(KIND_DEL_ALL, 32'sd0, 5'd0);
        queue_cmd(KIND_READ + 4'd7, 32'sd9, 5'd0);
        queue_cmd(KIND_INS_POS, 32'sd3, 5'd1);
        queue_cmd(KIND_INS_POS, 32'sd7, 5'd0);
        queue_cmd(KIND_INS_FRONT, 32'sh7fffffff, 5'd0);
        queue_cmd(KIND_INS_REAR, 32'sh80000000, 5'd0);
        queue_cmd(KIND_INS_POS, -32'sd1, 5'd3);
        // sorted insert into an unsorted list
        queue_cmd(KIND_INS_SORTED, 32'sd0, 5'd0);
        queue_cmd(KIND_INS_SORTED, 32'sh7fffffff, 5'd0);
        queue_cmd(KIND_READ, 32'sd0, 5'd31);
        queue_cmd(KIND_READ, 32'sd0, 5'd0);
        queue_cmd(KIND_READ, 32'sd0, 5'd5);
        queue_cmd(KIND_READ, 32'sd0, 5'd6);
        queue_cmd(KIND_DEL_FIRST, 32'sd12345, 5'd0);
        queue_cmd(KIND_DEL_ALL, 32'sd12345, 5'd0);
        queue_cmd(KIND_INS_REAR, 32'sd7, 5'd16);
        queue_cmd(KIND_DEL_ALL, 32'sd7, 5'd0);
        queue_cmd(KIND_DEL_ALL, 32'sh7fffffff, 5'd0);
        queue_cmd(KIND_DEL_FIRST, 32'sd0, 5'd0);
        queue_cmd(KIND_DEL_FRONT, 32'sd0, 5'd0);
        queue_cmd(KIND_DEL_REAR, 32'sd0, 5'd0);

        run_phase(0, 0);
        run_phase(57, 0);
        run_phase(0, 57);
        run_phase(37, 37);

        while (cmd_valid || pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
design/bli_pkg.sv
design/bli_cell.sv
design/bounded_list_insert_delete.sv
sim/bounded_list_insert_delete_test.sv
